// ===== rtl/sn83_pkg.sv =====
// Shared types, constants and character functions of the 8.3 short name generator.
`default_nettype none

package sn83_pkg;

  // Field widths and fixed constants of the short name format.
  localparam int CHAR_W        = 7;
  localparam int IN_CHAR_W     = 16;
  localparam int NUM_W         = 32;
  localparam int DIG_W         = 6;
  localparam int NDIG_W        = 3;
  localparam int CNT_W         = 3;
  localparam int NUM_DIGITS    = 6;
  localparam int DIGIT_BASE    = 42;
  localparam int BITS_PER_STEP = 8;
  localparam int STEP_W        = 2;
  localparam int BASE_LEN      = 7;
  localparam int EXT_LEN       = 3;

  localparam logic [IN_CHAR_W-1:0] DOT_CODE   = 16'h002E;
  localparam logic [CHAR_W-1:0]    DOT_CHAR   = 7'h2E;
  localparam logic [CHAR_W-1:0]    TILDE_CHAR = 7'h7E;

  // Controller states.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DIV,
    ST_BASE_RD,
    ST_BASE_CK,
    ST_TILDE,
    ST_DIGIT,
    ST_EXT_RD,
    ST_EXT_CK,
    ST_FLUSH
  } state_t;

  // Source of a character pushed toward the output.
  typedef enum logic [1:0] {
    SRC_STORE,
    SRC_TILDE,
    SRC_DIGIT,
    SRC_DOT
  } push_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      div_step;
    logic      base_init;
    logic      ext_init;
    logic      scan_next;
    logic      cnt_inc;
    logic      found_set;
    logic      digit_init;
    logic      digit_next;
    logic      push;
    push_src_t push_src;
    logic      flush;
  } sn83_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
    logic quot_zero;
    logic base_more;
    logic ext_more;
    logic data_nz;
    logic found;
    logic digit_last;
    logic dot_seen;
    logic out_free;
  } sn83_status_t;

  // Legal characters of an 8.3 name.
  function automatic logic is_legal(input logic [IN_CHAR_W-1:0] c);
    logic ok;
    ok = (c == 16'h0021) ||
         ((c >= 16'h0023) && (c <= 16'h0029)) ||
         (c == 16'h002D) ||
         ((c >= 16'h0030) && (c <= 16'h0039)) ||
         ((c >= 16'h0040) && (c <= 16'h005A)) ||
         ((c >= 16'h005E) && (c <= 16'h007B)) ||
         ((c >= 16'h007D) && (c <= 16'h007F));
    return ok;
  endfunction

  // Map lowercase letters to uppercase.
  function automatic logic [CHAR_W-1:0] upcase(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = ((c >= 7'h61) && (c <= 7'h7A)) ? (c - 7'd32) : c;
    return r;
  endfunction

  // Character for one base-42 digit.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] r;
    case (d)
      6'd0:    r = 7'h30;
      6'd1:    r = 7'h31;
      6'd2:    r = 7'h32;
      6'd3:    r = 7'h33;
      6'd4:    r = 7'h34;
      6'd5:    r = 7'h35;
      6'd6:    r = 7'h36;
      6'd7:    r = 7'h37;
      6'd8:    r = 7'h38;
      6'd9:    r = 7'h39;
      6'd10:   r = 7'h41;
      6'd11:   r = 7'h42;
      6'd12:   r = 7'h43;
      6'd13:   r = 7'h44;
      6'd14:   r = 7'h45;
      6'd15:   r = 7'h46;
      6'd16:   r = 7'h47;
      6'd17:   r = 7'h48;
      6'd18:   r = 7'h4A;
      6'd19:   r = 7'h4B;
      6'd20:   r = 7'h4C;
      6'd21:   r = 7'h4D;
      6'd22:   r = 7'h4E;
      6'd23:   r = 7'h4F;
      6'd24:   r = 7'h50;
      6'd25:   r = 7'h51;
      6'd26:   r = 7'h52;
      6'd27:   r = 7'h53;
      6'd28:   r = 7'h54;
      6'd29:   r = 7'h55;
      6'd30:   r = 7'h56;
      6'd31:   r = 7'h57;
      6'd32:   r = 7'h58;
      6'd33:   r = 7'h59;
      6'd34:   r = 7'h5A;
      6'd35:   r = 7'h5F;
      6'd36:   r = 7'h2D;
      6'd37:   r = 7'h24;
      6'd38:   r = 7'h23;
      6'd39:   r = 7'h21;
      6'd40:   r = 7'h7B;
      6'd41:   r = 7'h7D;
      default: r = 7'h30;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sn83_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none

module sn83_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/sn83_ctrl.sv =====
// Controller state machine of the 8.3 short name generator.
`default_nettype none

module sn83_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  is_last,
  output logic                  in_stall,
  output sn83_pkg::sn83_cmd_t   cmd,
  input  sn83_pkg::sn83_status_t status
);

  import sn83_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_valid && is_last) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_last && status.quot_zero) state_next = ST_BASE_RD;
      end
      ST_BASE_RD: begin
        state_next = status.base_more ? ST_BASE_CK : ST_TILDE;
      end
      ST_BASE_CK: begin
        if (!status.data_nz || status.out_free) state_next = ST_BASE_RD;
      end
      ST_TILDE: begin
        if (status.out_free) state_next = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (status.out_free && status.digit_last) begin
          state_next = status.dot_seen ? ST_EXT_RD : ST_FLUSH;
        end
      end
      ST_EXT_RD: begin
        state_next = status.ext_more ? ST_EXT_CK : ST_FLUSH;
      end
      ST_EXT_CK: begin
        if (!status.data_nz || (status.found && status.out_free)) state_next = ST_EXT_RD;
      end
      ST_FLUSH: begin
        if (status.out_free) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd          = '0;
    cmd.push_src = SRC_STORE;
    in_stall     = (state != ST_LOAD);
    case (state)
      ST_LOAD: begin
        cmd.load = in_valid;
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.base_init = status.div_last && status.quot_zero;
      end
      ST_BASE_CK: begin
        if (!status.data_nz) begin
          cmd.scan_next = 1'b1;
        end else if (status.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_src  = SRC_STORE;
          cmd.scan_next = 1'b1;
          cmd.cnt_inc   = 1'b1;
        end
      end
      ST_TILDE: begin
        if (status.out_free) begin
          cmd.push       = 1'b1;
          cmd.push_src   = SRC_TILDE;
          cmd.digit_init = 1'b1;
        end
      end
      ST_DIGIT: begin
        if (status.out_free) begin
          cmd.push       = 1'b1;
          cmd.push_src   = SRC_DIGIT;
          cmd.digit_next = 1'b1;
          cmd.ext_init   = status.digit_last && status.dot_seen;
        end
      end
      ST_EXT_CK: begin
        if (!status.data_nz) begin
          cmd.scan_next = 1'b1;
        end else if (status.out_free) begin
          cmd.push = 1'b1;
          if (!status.found) begin
            // The first legal extension character is preceded by the dot.
            cmd.push_src  = SRC_DOT;
            cmd.found_set = 1'b1;
          end else begin
            cmd.push_src  = SRC_STORE;
            cmd.scan_next = 1'b1;
            cmd.cnt_inc   = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        cmd.flush = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/sn83_datapath.sv =====
// Datapath of the 8.3 short name generator: name store, digit divider, scan and output.
`default_nettype none

module sn83_datapath #(
  parameter int MAX_NAME = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sn83_pkg::sn83_cmd_t               cmd,
  output sn83_pkg::sn83_status_t            status,
  input  logic [sn83_pkg::IN_CHAR_W-1:0]    name_char,
  input  logic [sn83_pkg::NUM_W-1:0]        file_number,
  input  logic                              is_last,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [sn83_pkg::CHAR_W-1:0]       short_char,
  output logic                              short_last,
  output logic                              overflow
);

  import sn83_pkg::*;

  localparam int LEN_W  = $clog2(MAX_NAME + 1);
  localparam int ADDR_W = $clog2(MAX_NAME);

  // Name bookkeeping.
  logic [LEN_W-1:0]  len;
  logic [ADDR_W-1:0] last_dot;
  logic              dot_seen;
  logic              ovf;

  // Digit divider.
  logic [NUM_W-1:0]         num_sh;
  logic [NUM_W-1:0]         num_sh_next;
  logic [DIG_W-1:0]         rem;
  logic [DIG_W-1:0]         rem_next;
  logic [BITS_PER_STEP-1:0] q_bits;
  logic [STEP_W-1:0]        step;
  logic [DIG_W-1:0]         digits [NUM_DIGITS];
  logic [NDIG_W-1:0]        nsize;

  // Scan and emission.
  logic [LEN_W-1:0]  idx;
  logic [CNT_W-1:0]  cnt;
  logic              found;
  logic [NDIG_W-1:0] k;
  logic [LEN_W-1:0]  base_end;
  logic [CNT_W-1:0]  limit;
  logic [CHAR_W-1:0] rd_data;
  logic [CHAR_W-1:0] push_char;
  logic              pend_valid;
  logic [CHAR_W-1:0] pend_char;
  logic              out_free;

  // Store write on each accepted nonzero character that fits.
  logic              wr_en;
  logic [CHAR_W-1:0] wr_data;

  assign wr_en   = cmd.load && (name_char != '0) && (len < LEN_W'(MAX_NAME));
  assign wr_data = is_legal(name_char) ? name_char[CHAR_W-1:0] : '0;

  sn83_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_NAME)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (len[ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (idx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // One step of the divide by 42: eight restoring quotient bits.
  always_comb begin
    logic [DIG_W:0] trial;
    rem_next = rem;
    q_bits   = '0;
    for (int b = 0; b < BITS_PER_STEP; b++) begin
      trial = {rem_next, num_sh[NUM_W-1-b]};
      if (trial >= (DIG_W+1)'(DIGIT_BASE)) begin
        rem_next                   = DIG_W'(trial - (DIG_W+1)'(DIGIT_BASE));
        q_bits[BITS_PER_STEP-1-b]  = 1'b1;
      end else begin
        rem_next = trial[DIG_W-1:0];
      end
    end
    num_sh_next = {num_sh[NUM_W-BITS_PER_STEP-1:0], q_bits};
  end

  // Name length, dot position and overflow flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      last_dot <= '0;
      dot_seen <= 1'b0;
      ovf      <= 1'b0;
    end else if (cmd.flush) begin
      len      <= '0;
      last_dot <= '0;
      dot_seen <= 1'b0;
      ovf      <= 1'b0;
    end else if (cmd.load && (name_char != '0)) begin
      if (len < LEN_W'(MAX_NAME)) begin
        len <= len + 1'b1;
        if (name_char == DOT_CODE) begin
          dot_seen <= 1'b1;
          last_dot <= len[ADDR_W-1:0];
        end
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // Divider registers and the digit list.
  always_ff @(posedge clk) begin
    if (cmd.load && is_last) begin
      num_sh <= file_number;
      rem    <= '0;
      step   <= '0;
      nsize  <= '0;
    end else if (cmd.div_step) begin
      num_sh <= num_sh_next;
      step   <= step + 1'b1;
      if (status.div_last) begin
        digits[nsize] <= rem_next;
        nsize         <= nsize + 1'b1;
        rem           <= '0;
      end else begin
        rem <= rem_next;
      end
    end
  end

  // Scan index, kept-character count and digit index.
  always_ff @(posedge clk) begin
    if (cmd.base_init) begin
      idx <= '0;
      cnt <= '0;
    end else if (cmd.ext_init) begin
      idx   <= LEN_W'(last_dot) + 1'b1;
      cnt   <= '0;
      found <= 1'b0;
    end else begin
      if (cmd.scan_next) idx <= idx + 1'b1;
      if (cmd.cnt_inc)   cnt <= cnt + 1'b1;
      if (cmd.found_set) found <= 1'b1;
    end
    if (cmd.digit_init) begin
      k <= '0;
    end else if (cmd.digit_next) begin
      k <= k + 1'b1;
    end
  end

  // Character selected for a push.
  always_comb begin
    case (cmd.push_src)
      SRC_STORE: push_char = upcase(rd_data);
      SRC_TILDE: push_char = TILDE_CHAR;
      SRC_DIGIT: push_char = digit_char(digits[k]);
      SRC_DOT:   push_char = DOT_CHAR;
      default:   push_char = TILDE_CHAR;
    endcase
  end

  // Pending character: held back one push so the final one can be marked.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end else if (cmd.push) begin
      pend_valid <= 1'b1;
    end
    if (cmd.push) begin
      pend_char <= push_char;
    end
  end

  // Output register.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.push && pend_valid) || cmd.flush) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if ((cmd.push && pend_valid) || cmd.flush) begin
      short_char <= pend_char;
      short_last <= cmd.flush;
      overflow   <= ovf;
    end
  end

  // Status to the controller.
  assign base_end = dot_seen ? LEN_W'(last_dot) : len;
  assign limit    = CNT_W'(BASE_LEN) - CNT_W'(nsize);

  assign status.div_last   = (step == STEP_W'(NUM_W / BITS_PER_STEP - 1));
  assign status.quot_zero  = (num_sh_next == '0);
  assign status.base_more  = (idx < base_end) && (cnt < limit);
  assign status.ext_more   = (idx < len) && (cnt < CNT_W'(EXT_LEN));
  assign status.data_nz    = (rd_data != '0);
  assign status.found      = found;
  assign status.digit_last = (k == (nsize - 1'b1));
  assign status.dot_seen   = dot_seen;
  assign status.out_free   = out_free;

endmodule

`default_nettype wire

// ===== rtl/short_name_8dot3_generator_unit.sv =====
// Top level of the 8.3 short name generator.
//
// Long-name characters are taken one per cycle and written into a name store of
// MAX_NAME entries; characters past the store are dropped and mark every result
// of that name with overflow. The transfer that carries is_last starts emission,
// during which input is stalled: the file number is divided by 42 at eight
// quotient bits per cycle into 1 to 6 digits, then the store is walked through
// its single registered read port before the last dot (until the base is full)
// and after it (until three are kept), each result waiting while the output is
// stalled; the next name is taken once the last result sits in the output register.
// The store needs no clearing after reset.
`default_nettype none

module short_name_8dot3_generator_unit #(
  parameter int MAX_NAME = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [sn83_pkg::IN_CHAR_W-1:0] name_char,
  input  logic [sn83_pkg::NUM_W-1:0]     file_number,
  input  logic                           is_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sn83_pkg::CHAR_W-1:0]    short_char,
  output logic                           short_last,
  output logic                           overflow
);

  import sn83_pkg::*;

  sn83_cmd_t    cmd;
  sn83_status_t status;

  // Sequencer.
  sn83_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .is_last  (is_last),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  // Store, divider, scan and output register.
  sn83_datapath #(
    .MAX_NAME (MAX_NAME)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .name_char   (name_char),
    .file_number (file_number),
    .is_last     (is_last),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .short_char  (short_char),
    .short_last  (short_last),
    .overflow    (overflow)
  );

endmodule

`default_nettype wire

// ===== rtl/sn83_checker.sv =====
// Port-level checks of the 8.3 short name generator and their binding.
`default_nettype none

module sn83_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       is_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] short_char,
  input logic       short_last,
  input logic       overflow
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(short_char) &&
      $stable(short_last) && $stable(overflow))
    else $error("stalled result changed");

  // A transfer that does not end a name leaves the input open.
  a_load_open: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !is_last |=> !in_stall)
    else $error("input closed in the middle of a name");

  // The transfer that ends a name closes the input for emission.
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && is_last |=> in_stall)
    else $error("input still open after the last character");

  // While a short name is only partly delivered, no new input is taken.
  a_emit_stalls: assert property (@(posedge clk) disable iff (rst)
    out_valid && !short_last |-> in_stall)
    else $error("input open during emission");

endmodule

bind short_name_8dot3_generator_unit sn83_checker u_sn83_checker (.*);

`default_nettype wire
